>>> hdl/kts_pkg.sv
// Shared types, constants and helpers of the k-mer table search block.
package kts_pkg;

	localparam int TABLE_DEPTH = 65536;
	localparam int MAX_K       = 32;
	localparam int KEY_W       = 64;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_LOOKUP   = 2'd1,
		OP_NEIGHBOR = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KMER_LENGTH = 1'd0,
		REG_ENTRY_COUNT = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ISSUE,
		ST_COMPARE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] entry_index;
		logic [63:0] key_value;
	} req_item_t;

	typedef struct packed {
		logic [63:0] probed_kmer;
		logic        found;
		logic [15:0] position;
		logic        last_of_run;
	} res_item_t;

	typedef struct packed {
		logic load;     // write table entry from the request
		logic capture;  // latch a lookup request
		logic start;    // begin a search for the current probe
		logic issue;    // read the table at mid
		logic update;   // narrow the interval with the read data
		logic emit;     // move the result to the output register
	} ctl_cmd_t;

	typedef struct packed {
		logic searching;
		logic last_probe;
		logic res_full;
	} dp_sts_t;

	// low 2*bases bits set; 32 or more bases gives the whole word
	function automatic logic [KEY_W-1:0] kmer_mask(input logic [5:0] bases);
		logic [KEY_W-1:0] m;
		if (bases >= 6'd32)
			m = '1;
		else
			m = (KEY_W'(1) << {bases, 1'b0}) - KEY_W'(1);
		return m;
	endfunction

endpackage

>>> hdl/kts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/kts_ctrl.sv
// Sequencing state machine: request intake, search steps, result hand-off.
module kts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  kts_pkg::op_t     op,
	input  kts_pkg::dp_sts_t sts,
	output kts_pkg::ctl_cmd_t cmd
);

	kts_pkg::state_t state_q, state_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= kts_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		accept    = 1'b0;
		unique case (state_q)
			kts_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
				if (accept) begin
					unique case (op) inside
						kts_pkg::OP_LOAD: cmd.load = 1'b1;
						kts_pkg::OP_LOOKUP, kts_pkg::OP_NEIGHBOR: begin
							cmd.capture = 1'b1;
							state_d     = kts_pkg::ST_INIT;
						end
						default: ;
					endcase
				end
			end
			kts_pkg::ST_INIT: begin
				cmd.start = 1'b1;
				state_d   = kts_pkg::ST_ISSUE;
			end
			kts_pkg::ST_ISSUE: begin
				if (sts.searching) begin
					cmd.issue = 1'b1;
					state_d   = kts_pkg::ST_COMPARE;
				end else
					state_d = kts_pkg::ST_EMIT;
			end
			kts_pkg::ST_COMPARE: begin
				cmd.update = 1'b1;
				state_d    = kts_pkg::ST_ISSUE;
			end
			kts_pkg::ST_EMIT: begin
				if (!sts.res_full) begin
					cmd.emit = 1'b1;
					state_d  = sts.last_probe ? kts_pkg::ST_IDLE : kts_pkg::ST_INIT;
				end
			end
			default: state_d = kts_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> hdl/kts_dp.sv
// Datapath: config registers, table RAM, probe key build, lower-bound search.
module kts_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kts_pkg::req_item_t                 req,
	input  kts_pkg::ctl_cmd_t                  cmd,
	output kts_pkg::dp_sts_t                   sts,
	input  logic                               cfg_write,
	input  logic [kts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kts_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output kts_pkg::res_item_t                 res
);

	localparam int AW = kts_pkg::ADDR_W;
	localparam int CW = kts_pkg::CNT_W;
	localparam int KW = kts_pkg::KEY_W;

	logic [5:0]  kmer_length_q;
	logic [16:0] entry_count_q;

	logic [KW-1:0] raw_q, key_q;
	logic          neighbor_q;
	logic [5:0]    k_q;
	logic [2:0]    pidx_q;
	logic [CW-1:0] n_q, lo_q, hi_q, mid_q;
	logic          eq_q;
	kts_pkg::res_item_t res_q;
	logic          res_valid_q;

	logic [5:0]    k_eff, km1;
	logic [31:0]   ec32, idx32;
	logic [CW-1:0] n_sat, mid;
	logic [KW-1:0] mask_k, shorter, probe_key;
	logic [5:0]    sh;
	logic [KW-1:0] rdata;
	logic          wr_en;
	logic [CW+15:0] pos_ext;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= 6'd32;
			entry_count_q <= '0;
		end else if (cfg_write) begin
			unique case (kts_pkg::cfg_reg_t'(cfg_index))
				kts_pkg::REG_KMER_LENGTH: kmer_length_q <= cfg_data[5:0];
				kts_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (kmer_length_q < 6'd2)
			k_eff = 6'd2;
		else if (kmer_length_q > 6'(kts_pkg::MAX_K))
			k_eff = 6'(kts_pkg::MAX_K);
		else
			k_eff = kmer_length_q;
		ec32  = {15'd0, entry_count_q};
		n_sat = (ec32 > 32'(kts_pkg::TABLE_DEPTH)) ? CW'(kts_pkg::TABLE_DEPTH)
		                                           : ec32[CW-1:0];
		idx32 = {16'd0, req.entry_index};
		wr_en = cmd.load && (idx32 < 32'(kts_pkg::TABLE_DEPTH));
	end

	// probe key: plain lookup, 4 prepends, then 4 appends
	always_comb begin
		km1     = k_q - 6'd1;
		sh      = {km1[4:0], 1'b0};
		mask_k  = kts_pkg::kmer_mask(k_q);
		shorter = raw_q & kts_pkg::kmer_mask(km1);
		if (!neighbor_q)
			probe_key = raw_q & mask_k;
		else if (!pidx_q[2])
			probe_key = (KW'(pidx_q[1:0]) << sh) | shorter;
		else
			probe_key = ((shorter << 2) | KW'(pidx_q[1:0])) & mask_k;
	end

	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	kts_ram #(.WIDTH(KW), .DEPTH(kts_pkg::TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx32[AW-1:0]),
		.wdata (req.key_value),
		.re    (cmd.issue),
		.raddr (mid[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q      <= req.key_value;
			neighbor_q <= (req.operation == kts_pkg::OP_NEIGHBOR);
			k_q        <= k_eff;
			n_q        <= n_sat;
		end
		if (cmd.start) begin
			key_q <= probe_key;
			lo_q  <= '0;
			hi_q  <= n_q;
			eq_q  <= 1'b0;
		end
		if (cmd.issue)
			mid_q <= mid;
		// eq_q follows the last time hi moved; the search ends with lo on hi
		if (cmd.update) begin
			if (rdata < key_q)
				lo_q <= mid_q + CW'(1);
			else begin
				hi_q <= mid_q;
				eq_q <= (rdata == key_q);
			end
		end
		if (cmd.emit) begin
			res_q.probed_kmer <= key_q;
			res_q.found       <= eq_q;
			res_q.position    <= eq_q ? pos_ext[15:0] : 16'd0;
			res_q.last_of_run <= sts.last_probe;
		end
	end

	assign pos_ext = {16'd0, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.capture)
				pidx_q <= '0;
			else if (cmd.emit)
				pidx_q <= pidx_q + 3'd1;
			if (cmd.emit)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.searching  = lo_q < hi_q;
		sts.last_probe = !neighbor_q || (pidx_q == 3'd7);
		sts.res_full   = res_valid_q && res_stall;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hdl/kmer_table_neighbor_search.sv
// K-mer table with binary-search lookup and (k-1)-mer neighbour lookup.
// Each probe is a lower-bound search of at most S = ceil(log2(n+1)) halvings,
// each a RAM read, then a compare, with n = entry count. A neighbour lookup
// runs 8 probes. One request in flight at a time.
// Reset clears control state and config registers (k = 32, entry count 0); table is not cleared.
module kmer_table_neighbor_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  kts_pkg::req_item_t                 req,
	output logic                               res_valid,
	input  logic                               res_stall,
	output kts_pkg::res_item_t                 res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kts_pkg::CFG_DATA_W-1:0]     cfg_data
);

	kts_pkg::ctl_cmd_t cmd;
	kts_pkg::dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	kts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (req.operation),
		.sts       (sts),
		.cmd       (cmd)
	);

	kts_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
